[rtl/ofw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ofw_pkg;

   // Field widths of the control word.
   localparam int OCT_W  = 4;
   localparam int DAC_W  = 10;
   localparam int CNF_W  = 2;
   localparam int WORD_W = 16;

   // Quotient bits kept by the divider. Within a valid band the quotient stays
   // below 2^QUO_W, so no saturation is needed.
   localparam int QUO_W = 12;

   // DAC = 2048 - floor(2078 * 2^(10 + oct) / f), clamped to 0..1023.
   localparam logic [QUO_W-1:0] NUM_SCALE   = 12'd2078;
   localparam int               SCALE_SHIFT = 10;
   localparam logic [QUO_W-1:0] DAC_MID     = 12'd2048;
   localparam logic [QUO_W-1:0] DAC_MAX     = 12'd1023;

   // Lower frequency threshold of each octave band; the last entry is the
   // first frequency above range.
   localparam int NUM_BANDS = 16;
   localparam logic [31:0] BAND_FLOOR [0:NUM_BANDS] = '{
      32'd1039,     32'd2076,     32'd4152,     32'd8304,
      32'd16610,    32'd33220,    32'd66430,    32'd132900,
      32'd265700,   32'd531400,   32'd1063000,  32'd2126000,
      32'd4252000,  32'd8503000,  32'd17010000, 32'd34010000,
      32'd68030000
   };

   typedef enum logic [1:0] {
      OP_SET_FREQ = 2'd0,
      OP_SET_RAW  = 2'd1,
      OP_ENABLE   = 2'd2,
      OP_DISABLE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_SENT  = 2'd0,
      ST_BELOW = 2'd1,
      ST_ABOVE = 2'd2,
      ST_NONE  = 2'd3
   } status_type;

   typedef enum logic {
      CSR_MAIN_CLK = 1'b0,
      CSR_INV_CLK  = 1'b1
   } csr_type;

   // Side information that travels with an item through the divider.
   typedef struct packed {
      status_type       status;
      logic             oe;
      logic             use_quo;
      logic [OCT_W-1:0] oct;
      logic [DAC_W-1:0] dac;
   } meta_type;

endpackage

`default_nettype wire

[rtl/ofw_div_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per register stage, most significant first.
module ofw_div_pipe #(
   parameter int DEN_W = 27
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire logic                                in_valid,
   input  wire logic [DEN_W+ofw_pkg::QUO_W-1:0]     in_num,
   input  wire logic [DEN_W-1:0]                    in_den,
   input  wire ofw_pkg::meta_type                   in_meta,
   output logic                                     out_valid,
   output logic [ofw_pkg::QUO_W-1:0]                out_quo,
   output ofw_pkg::meta_type                        out_meta
);
   import ofw_pkg::*;

   localparam int REM_W = DEN_W + QUO_W;

   logic             valid_ff [QUO_W];
   logic [REM_W-1:0] rem_ff   [QUO_W-1];
   logic [DEN_W-1:0] den_ff   [QUO_W-1];
   logic [QUO_W-1:0] quo_ff   [QUO_W];
   meta_type         meta_ff  [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      localparam int SH = QUO_W - 1 - j;

      logic             valid_cur;
      logic [REM_W-1:0] rem_cur;
      logic [DEN_W-1:0] den_cur;
      logic [QUO_W-1:0] quo_cur;
      meta_type         meta_cur;
      logic [REM_W-1:0] den_sh;
      logic [REM_W-1:0] diff;
      logic             take;
      logic [QUO_W-1:0] quo_in;

      if (j == 0) begin : g_first
         assign valid_cur = in_valid;
         assign rem_cur   = in_num;
         assign den_cur   = in_den;
         assign quo_cur   = '0;
         assign meta_cur  = in_meta;
      end else begin : g_next
         assign valid_cur = valid_ff[j-1];
         assign rem_cur   = rem_ff[j-1];
         assign den_cur   = den_ff[j-1];
         assign quo_cur   = quo_ff[j-1];
         assign meta_cur  = meta_ff[j-1];
      end

      assign den_sh = REM_W'(den_cur) << SH;
      assign take   = (rem_cur >= den_sh);
      assign diff   = rem_cur - den_sh;

      always_comb begin
         quo_in     = quo_cur;
         quo_in[SH] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (advance) begin
            valid_ff[j] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            quo_ff[j]  <= quo_in;
            meta_ff[j] <= meta_cur;
         end
      end

      // The partial remainder and divisor are only needed by a later stage.
      if (j < QUO_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[j] <= take ? diff : rem_cur;
               den_ff[j] <= den_cur;
            end
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_meta  = meta_ff[QUO_W-1];

endmodule

`default_nettype wire

[rtl/oscillator_frequency_word.sv]
`timescale 1ns / 1ps
`default_nettype none

// Oscillator control-word builder. Each command transfer on the req_ channel
// produces exactly one result transfer on the rsp_ channel, in order. Opcode
// set-by-frequency picks the octave band from sixteen fixed thresholds and
// computes DAC = 2048 - floor(2078 * 2^(10+oct) / f), clamped to 0..1023;
// opcode set-raw takes octave and DAC code as given. The 16-bit word is
// octave in bits 15..12, DAC in bits 11..2 and both clock-configuration
// bits in 1..0, the latter being the inverses of the csr_ enable registers.
// Sending a word, or an enable command, drives the output enable high; a
// disable command drives it low; a frequency below 1039 Hz or at or above
// 68030000 Hz sends no word, leaves the output enable as it was and reports
// below-range or above-range status. The block is a fully pipelined design
// that accepts one command every clock cycle while the result is not
// stalled. A request transfer loads the input register, and then passes
// through the octave-select stage, twelve divider stages that each resolve
// one quotient bit, and the output register before its result appears on
// rsp_valid. When the result is stalled the whole pipeline holds, and
// req_stall is raised in the same cycle. Configuration writes are expected
// only while no command is in flight.
module oscillator_frequency_word #(
   parameter int FREQUENCY_WIDTH = 27
) (
   input  wire logic                        clock,
   input  wire logic                        reset,

   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_opcode,
   input  wire logic [FREQUENCY_WIDTH-1:0]  req_target_frequency,
   input  wire logic [ofw_pkg::OCT_W-1:0]   req_raw_octave,
   input  wire logic [ofw_pkg::DAC_W-1:0]   req_raw_dac,

   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [ofw_pkg::WORD_W-1:0]       rsp_control_word,
   output logic [ofw_pkg::OCT_W-1:0]        rsp_octave_used,
   output logic [ofw_pkg::DAC_W-1:0]        rsp_dac_used,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_output_enable,

   input  wire logic                        csr_write,
   input  wire logic                        csr_index,
   input  wire logic                        csr_data
);
   import ofw_pkg::*;

   localparam int REM_W = FREQUENCY_WIDTH + QUO_W;

   // The pipeline moves as a whole whenever the output register is empty or
   // its contents are being transferred out.
   logic advance;
   logic accept;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // Configuration registers.
   logic main_clk_ff;
   logic inv_clk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_clk_ff <= 1'b1;
         inv_clk_ff  <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_type'(csr_index))
            CSR_MAIN_CLK: main_clk_ff <= csr_data;
            CSR_INV_CLK:  inv_clk_ff  <= csr_data;
         endcase
      end
   end

   // Input decode. The output-enable level is the only state carried between
   // commands, and it is resolved here in transfer order so that later stages
   // only have to carry it along.
   logic [31:0] freq32;
   logic        below;
   logic        above;
   logic        oe_ff;
   logic        oe_in;
   meta_type    meta0;

   assign freq32 = 32'(req_target_frequency);
   assign below  = (freq32 < BAND_FLOOR[0]);
   assign above  = (freq32 >= BAND_FLOOR[NUM_BANDS]);

   always_comb begin
      oe_in         = oe_ff;
      meta0.status  = ST_NONE;
      meta0.use_quo = 1'b0;
      meta0.oct     = req_raw_octave;
      meta0.dac     = req_raw_dac;
      unique case (op_type'(req_opcode))
         OP_SET_FREQ: begin
            if (below) begin
               meta0.status = ST_BELOW;
            end else if (above) begin
               meta0.status = ST_ABOVE;
            end else begin
               meta0.status  = ST_SENT;
               meta0.use_quo = 1'b1;
               oe_in         = 1'b1;
            end
         end
         OP_SET_RAW: begin
            meta0.status = ST_SENT;
            oe_in        = 1'b1;
         end
         OP_ENABLE: begin
            oe_in = 1'b1;
         end
         OP_DISABLE: begin
            oe_in = 1'b0;
         end
      endcase
      meta0.oe = oe_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oe_ff <= 1'b0;
      end else if (accept) begin
         oe_ff <= oe_in;
      end
   end

   // Stage 0: registered command.
   logic                       s0_valid_ff;
   meta_type                   s0_meta_ff;
   logic [FREQUENCY_WIDTH-1:0] s0_freq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_meta_ff <= meta0;
         s0_freq_ff <= req_target_frequency;
      end
   end

   // Stage 1: octave band select and dividend. The thresholds rise
   // monotonically, so the band is the last threshold the frequency reaches.
   logic [31:0]      s0_freq32;
   logic [OCT_W-1:0] band;
   meta_type         meta1;
   logic [REM_W-1:0] num_in;

   assign s0_freq32 = 32'(s0_freq_ff);

   always_comb begin
      band = '0;
      for (int i = 1; i < NUM_BANDS; i++) begin
         if (s0_freq32 >= BAND_FLOOR[i]) begin
            band = OCT_W'(i);
         end
      end
      meta1 = s0_meta_ff;
      if (s0_meta_ff.use_quo) begin
         meta1.oct = band;
      end
   end

   assign num_in = REM_W'(NUM_SCALE) << (SCALE_SHIFT + int'(meta1.oct));

   logic                       s1_valid_ff;
   meta_type                   s1_meta_ff;
   logic [FREQUENCY_WIDTH-1:0] s1_freq_ff;
   logic [REM_W-1:0]           s1_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_meta_ff <= meta1;
         s1_freq_ff <= s0_freq_ff;
         s1_num_ff  <= num_in;
      end
   end

   // Divider pipeline. Items that need no quotient pass through it unchanged.
   logic             div_valid;
   logic [QUO_W-1:0] div_quo;
   meta_type         div_meta;

   ofw_div_pipe #(
      .DEN_W (FREQUENCY_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s1_valid_ff),
      .in_num    (s1_num_ff),
      .in_den    (s1_freq_ff),
      .in_meta   (s1_meta_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_meta  (div_meta)
   );

   // Output stage: DAC clamp and word packing.
   logic [QUO_W-1:0]  dac_diff;
   logic [DAC_W-1:0]  dac_calc;
   logic [OCT_W-1:0]  oct_out;
   logic [DAC_W-1:0]  dac_out;
   logic [WORD_W-1:0] word_out;
   logic [CNF_W-1:0]  cnf;

   assign dac_diff = DAC_MID - div_quo;
   assign cnf      = {!inv_clk_ff, !main_clk_ff};

   always_comb begin
      if (div_quo >= DAC_MID) begin
         dac_calc = '0;
      end else if (dac_diff > DAC_MAX) begin
         dac_calc = DAC_W'(DAC_MAX);
      end else begin
         dac_calc = dac_diff[DAC_W-1:0];
      end

      if (div_meta.status == ST_SENT) begin
         oct_out  = div_meta.oct;
         dac_out  = div_meta.use_quo ? dac_calc : div_meta.dac;
         word_out = {oct_out, dac_out, cnf};
      end else begin
         oct_out  = '0;
         dac_out  = '0;
         word_out = '0;
      end
   end

   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_word_ff;
   logic [OCT_W-1:0]  rsp_oct_ff;
   logic [DAC_W-1:0]  rsp_dac_ff;
   status_type        rsp_status_ff;
   logic              rsp_oe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff   <= word_out;
         rsp_oct_ff    <= oct_out;
         rsp_dac_ff    <= dac_out;
         rsp_status_ff <= div_meta.status;
         rsp_oe_ff     <= div_meta.oe;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_control_word  = rsp_word_ff;
   assign rsp_octave_used   = rsp_oct_ff;
   assign rsp_dac_used      = rsp_dac_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_output_enable = rsp_oe_ff;

endmodule

`default_nettype wire

[rtl/ofw_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module ofw_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   input  wire logic [ofw_pkg::WORD_W-1:0]  rsp_control_word,
   input  wire logic [ofw_pkg::OCT_W-1:0]   rsp_octave_used,
   input  wire logic [ofw_pkg::DAC_W-1:0]   rsp_dac_used,
   input  wire logic [1:0]                  rsp_status
);
   import ofw_pkg::*;

   // A stalled result keeps its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_control_word))
      else $error("stalled result changed");

   // No result may be left over from before reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A sent word carries the reported octave and DAC code.
   a_word_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_SENT) |->
         (rsp_control_word[15:12] == rsp_octave_used) &&
         (rsp_control_word[11:2] == rsp_dac_used))
      else $error("word fields disagree with reported values");

   // Without a word, the word, octave and DAC fields are zero.
   a_no_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_SENT) |->
         (rsp_control_word == '0) && (rsp_octave_used == '0) && (rsp_dac_used == '0))
      else $error("fields not cleared when no word is sent");

endmodule

bind oscillator_frequency_word ofw_checker u_ofw_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_control_word (rsp_control_word),
   .rsp_octave_used  (rsp_octave_used),
   .rsp_dac_used     (rsp_dac_used),
   .rsp_status       (rsp_status)
);

`default_nettype wire
